### hdl/hpe_pkg.sv
// Shared constants and types of the Horner polynomial evaluator.
package hpe_pkg;

	localparam int NUM_COEF       = 8;
	localparam int IDX_W          = $clog2(NUM_COEF);
	localparam int DATA_W         = 32;
	localparam int PROD_W         = 2 * DATA_W;
	localparam int APB_ADDR_W     = IDX_W + 2;
	localparam int MAX_DEGREE_DEF = 7;
	localparam int FRAC_BITS_DEF  = 16;

	typedef logic [NUM_COEF-1:0][DATA_W-1:0] coef_arr_t;

	typedef struct packed {
		logic              start;
		logic              mul;
		logic              add;
		logic [DATA_W-1:0] coef;
	} mac_ctrl_t;

endpackage

### hdl/hpe_cfg.sv
// APB coefficient register file.
module hpe_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [hpe_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output hpe_pkg::coef_arr_t               coefs
);

	hpe_pkg::coef_arr_t               coef_q;
	logic [hpe_pkg::IDX_W-1:0]        reg_idx;

	assign reg_idx = paddr[hpe_pkg::APB_ADDR_W-1:2];
	assign pready  = 1'b1;
	assign prdata  = coef_q[reg_idx];
	assign coefs   = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (psel && penable && pwrite) begin
			coef_q[reg_idx] <= pwdata;
		end
	end

endmodule

### hdl/hpe_mac.sv
// Shared multiply, round, add and saturate unit with accumulator.
module hpe_mac #(
	parameter int FRAC_BITS = hpe_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [hpe_pkg::DATA_W-1:0]    x_point,
	input  hpe_pkg::mac_ctrl_t            ctrl,
	output logic [hpe_pkg::DATA_W-1:0]    acc,
	output logic                          sat
);

	localparam int W = hpe_pkg::PROD_W + 1;
	localparam logic signed [W-1:0] HALF = (W'(1) << FRAC_BITS) >> 1;
	localparam logic signed [W-1:0] SAT_MAX = (W'(1) <<< (hpe_pkg::DATA_W - 1)) - W'(1);
	localparam logic signed [W-1:0] SAT_MIN = -(W'(1) <<< (hpe_pkg::DATA_W - 1));

	logic signed [hpe_pkg::DATA_W-1:0] x_q;
	logic signed [hpe_pkg::DATA_W-1:0] acc_q;
	logic                              sat_q;
	logic signed [hpe_pkg::PROD_W-1:0] prod_s1;
	logic signed [W-1:0]               rnd;
	logic signed [W-1:0]               sum;
	logic                              hi;
	logic                              lo;

	assign rnd = ($signed({prod_s1[hpe_pkg::PROD_W-1], prod_s1}) + HALF) >>> FRAC_BITS;
	assign sum = rnd + W'($signed(ctrl.coef));
	assign hi  = sum > SAT_MAX;
	assign lo  = sum < SAT_MIN;

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_s1 <= x_q * acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			acc_q <= '0;
			sat_q <= 1'b0;
		end else if (ctrl.start) begin
			x_q   <= x_point;
			acc_q <= ctrl.coef;
			sat_q <= 1'b0;
		end else if (ctrl.add) begin
			if (hi) begin
				acc_q <= SAT_MAX[hpe_pkg::DATA_W-1:0];
			end else if (lo) begin
				acc_q <= SAT_MIN[hpe_pkg::DATA_W-1:0];
			end else begin
				acc_q <= sum[hpe_pkg::DATA_W-1:0];
			end
			sat_q <= sat_q | hi | lo;
		end
	end

	assign acc = acc_q;
	assign sat = sat_q;

endmodule

### hdl/hpe_seq.sv
// Horner step sequencer with output register.
module hpe_seq #(
	parameter int MAX_DEGREE = hpe_pkg::MAX_DEGREE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hpe_pkg::DATA_W-1:0]    m_value,
	output logic                          m_ovf,
	input  hpe_pkg::coef_arr_t            coefs,
	input  logic [hpe_pkg::DATA_W-1:0]    acc,
	input  logic                          sat,
	output hpe_pkg::mac_ctrl_t            ctrl
);

	typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD, S_FIN} state_t;

	state_t                         state_q;
	logic [hpe_pkg::IDX_W-1:0]      idx_q;
	logic [hpe_pkg::IDX_W-1:0]      top;
	logic [hpe_pkg::IDX_W-1:0]      idx_dn;
	logic                           m_tvalid_q;
	logic [hpe_pkg::DATA_W-1:0]     m_value_q;
	logic                           m_ovf_q;

	// highest nonzero coefficient, 0 when all are zero
	always_comb begin
		top = '0;
		for (int i = 0; i <= MAX_DEGREE; i++) begin
			if (coefs[i] != '0) begin
				top = hpe_pkg::IDX_W'(i);
			end
		end
	end

	assign idx_dn     = idx_q - hpe_pkg::IDX_W'(1);
	assign s_tready   = (state_q == S_IDLE);
	assign ctrl.start = s_tvalid && (state_q == S_IDLE);
	assign ctrl.mul   = (state_q == S_MUL);
	assign ctrl.add   = (state_q == S_ADD);
	assign ctrl.coef  = ctrl.start ? coefs[top] : coefs[idx_dn];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_value_q  <= '0;
			m_ovf_q    <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != S_FIN)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						idx_q   <= top;
						state_q <= (top != '0) ? S_MUL : S_FIN;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					idx_q   <= idx_dn;
					state_q <= (idx_dn == '0) ? S_FIN : S_MUL;
				end
				S_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_value_q  <= acc;
						m_ovf_q    <= sat;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_value  = m_value_q;
	assign m_ovf    = m_ovf_q;

endmodule

### hdl/horner_polynomial_evaluator_top.sv
// Top level of the Horner polynomial evaluator.
//
//   channel   direction  handshake                 payload
//   s_axis    in         s_tvalid / s_tready       s_tdata = x_point
//   m_axis    out        m_tvalid / m_tready       m_tdata = value, m_tuser = overflow
//   apb       in         psel, penable, pready     coef_0..coef_7 at 4*i
//
// The result is registered in the output register from state S_FIN, and s_tready returns
// in the same cycle that the result becomes valid. The number of Horner steps is d, the
// index of the highest nonzero coefficient (no steps when all are zero).
// Each Horner step passes through the shared 32x32 multiplier (S_MUL) and then the
// round, add and saturate path (S_ADD). One item is in work at a time; s_tready is low
// meanwhile. A stalled result holds in the output register and blocks the next one.
module horner_polynomial_evaluator_top #(
	parameter int MAX_DEGREE = hpe_pkg::MAX_DEGREE_DEF,
	parameter int FRAC_BITS  = hpe_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [31:0]                      s_tdata,   // [31:0] x_point
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [31:0]                      m_tdata,   // [31:0] value
	output logic [0:0]                       m_tuser,   // [0] overflow
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [hpe_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	hpe_pkg::coef_arr_t          coefs;
	hpe_pkg::mac_ctrl_t          ctrl;
	logic [hpe_pkg::DATA_W-1:0]  acc;
	logic                        sat;
	logic                        ovf;

	hpe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coefs   (coefs)
	);

	hpe_seq #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_value  (m_tdata),
		.m_ovf    (ovf),
		.coefs    (coefs),
		.acc      (acc),
		.sat      (sat),
		.ctrl     (ctrl)
	);

	hpe_mac #(
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.x_point (s_tdata),
		.ctrl    (ctrl),
		.acc     (acc),
		.sat     (sat)
	);

	assign m_tuser = ovf;

endmodule

### hdl/hpe_checker.sv
// Port-level checks of the Horner polynomial evaluator and their bind.
module hpe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without work in progress");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind horner_polynomial_evaluator_top hpe_checker u_hpe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.pready   (pready)
);
